FILE: rtl/core/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types, constants and helper functions of the packed track decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  // Rows in one track; the row counter saturates here.
  localparam int RowsPerTrack = 64;
  localparam int RowW         = 7;  // row counter holds 0 .. RowsPerTrack

  // Byte fields.
  localparam logic [7:0] SkipFlag  = 8'h80;
  localparam logic [6:0] ParamMask = 7'h7f;
  localparam logic [6:0] SpeedMax  = 7'd31;

  // Effect nibble codes of the packed stream.
  localparam logic [3:0] FxArpeggio = 4'h0;
  localparam logic [3:0] FxPortaUp  = 4'h1;
  localparam logic [3:0] FxPortaDn  = 4'h2;
  localparam logic [3:0] FxTonePort = 4'h3;
  localparam logic [3:0] FxVolume   = 4'h4;
  localparam logic [3:0] FxJump     = 4'h5;
  localparam logic [3:0] FxBreak    = 4'h6;
  localparam logic [3:0] FxSpeed    = 4'h7;
  localparam logic [3:0] FxVibrato  = 4'h8;
  localparam logic [3:0] FxSlide    = 4'h9;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_VOLUME   = 3'd1,
    KIND_JUMP     = 3'd2,
    KIND_BREAK    = 3'd3,
    KIND_SPEED    = 3'd4,
    KIND_UNMAPPED = 3'd5
  } effect_kind_e;

  // Position within a three-byte event.
  typedef enum logic [2:0] {
    PH_PARAM = 3'b001,
    PH_CMD   = 3'b010,
    PH_NOTE  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       track_start;
    logic       module_start;
  } in_item_t;

  typedef struct packed {
    logic       event_valid;
    logic [5:0] row;
    logic [6:0] note;
    logic [4:0] instrument;
    logic [2:0] effect_kind;
    logic [6:0] effect_param;
    logic [3:0] effect_raw;
    logic       track_end;
  } out_item_t;

  // Decoder state exposed to the top level for checking.
  typedef struct packed {
    logic            finished;
    logic [RowW-1:0] row;
  } dec_status_t;

  // Note offset for an octave: (2 + octave) * 12.
  function automatic logic [6:0] octave_offset(input logic [2:0] octave);
    logic [6:0] off;
    case (octave)
      3'd0:    off = 7'd24;
      3'd1:    off = 7'd36;
      3'd2:    off = 7'd48;
      3'd3:    off = 7'd60;
      3'd4:    off = 7'd72;
      3'd5:    off = 7'd84;
      3'd6:    off = 7'd96;
      3'd7:    off = 7'd108;
      default: off = 7'd24;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ptd_in_if.sv
// ----------------------------------------------------------------------------
// ptd_in_if
// Valid/ready channel carrying one byte of packed track data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptd_in_if;
  logic              valid;
  logic              ready;
  ptd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ptd_out_if.sv
// ----------------------------------------------------------------------------
// ptd_out_if
// Valid/ready channel carrying one decoded event word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptd_out_if;
  logic               valid;
  logic               ready;
  ptd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ptd_input_stage.sv
// ----------------------------------------------------------------------------
// ptd_input_stage
// Input register: captures one byte word and holds it until decoded.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_input_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire ptd_pkg::in_item_t in_data_i,
  output logic                   in_ready_o,
  input  wire logic              advance_i,
  output logic                   valid_o,
  output ptd_pkg::in_item_t      data_o
);

  logic              valid_q, valid_d;
  ptd_pkg::in_item_t data_q;
  logic              load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/ptd_decode.sv
// ----------------------------------------------------------------------------
// ptd_decode
// Track state and the byte decoder: phase, row, tempo mode, held event parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_decode (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ptd_pkg::in_item_t   item_i,
  input  wire logic                fire_i,
  output logic                     has_result_o,
  output ptd_pkg::out_item_t       result_o,
  output ptd_pkg::dec_status_t     status_o
);

  localparam int RowW = ptd_pkg::RowW;
  localparam logic [RowW-1:0] RowsEnd = RowW'(ptd_pkg::RowsPerTrack);

  ptd_pkg::phase_e phase_q, phase_d, phase_in;
  logic [RowW-1:0] row_q, row_d, row_in;
  logic            tempo_q, tempo_d, tempo_in;
  logic            fin_q, fin_d, fin_in;
  logic [6:0]      param_q, param_d;
  logic [3:0]      ins_hi_q, ins_hi_d;
  ptd_pkg::effect_kind_e kind_q, kind_d;
  logic [3:0]      raw_q, raw_d;

  logic            start;
  logic [7:0]      b;
  logic [RowW:0]   skip_sum;
  logic [RowW:0]   row_inc;
  logic [3:0]      nib;
  logic [6:0]      note;

  assign b     = item_i.track_byte;
  assign start = item_i.track_start || item_i.module_start;

  always_comb begin
    tempo_in = item_i.module_start ? 1'b0 : tempo_q;
    phase_in = start ? ptd_pkg::PH_PARAM : phase_q;
    row_in   = start ? '0 : row_q;
    fin_in   = start ? 1'b0 : fin_q;

    phase_d  = phase_in;
    row_d    = row_in;
    tempo_d  = tempo_in;
    fin_d    = fin_in;
    param_d  = param_q;
    ins_hi_d = ins_hi_q;
    kind_d   = kind_q;
    raw_d    = raw_q;

    skip_sum = {1'b0, row_in} + {1'b0, b[6:0]};
    row_inc  = {1'b0, row_in} + (RowW+1)'(1);
    nib      = b[7:4];
    note     = (nib == 4'd0) ? 7'd0 : ({3'b0, nib} + ptd_pkg::octave_offset(b[3:1]));

    has_result_o = 1'b0;
    result_o     = '0;

    if (!fin_in) begin
      case (phase_in)
        ptd_pkg::PH_PARAM: begin
          if ((b & ptd_pkg::SkipFlag) != 8'd0) begin
            if (skip_sum >= {1'b0, RowsEnd}) begin
              // Skip runs past the last row: report the end with no event.
              row_d                = RowsEnd;
              fin_d                = 1'b1;
              has_result_o         = 1'b1;
              result_o.track_end   = 1'b1;
            end else begin
              row_d = skip_sum[RowW-1:0];
            end
          end else begin
            param_d = b[6:0] & ptd_pkg::ParamMask;
            phase_d = ptd_pkg::PH_CMD;
          end
        end
        ptd_pkg::PH_CMD: begin
          ins_hi_d = b[7:4];
          raw_d    = b[3:0];
          phase_d  = ptd_pkg::PH_NOTE;
          case (b[3:0])
            ptd_pkg::FxArpeggio: kind_d = ptd_pkg::KIND_NONE;
            ptd_pkg::FxVolume:   kind_d = ptd_pkg::KIND_VOLUME;
            ptd_pkg::FxJump:     kind_d = ptd_pkg::KIND_JUMP;
            ptd_pkg::FxBreak:    kind_d = ptd_pkg::KIND_BREAK;
            ptd_pkg::FxPortaUp, ptd_pkg::FxPortaDn, ptd_pkg::FxTonePort,
            ptd_pkg::FxVibrato, ptd_pkg::FxSlide: begin
              kind_d  = ptd_pkg::KIND_NONE;
              param_d = 7'd0;
            end
            ptd_pkg::FxSpeed: begin
              // A zero speed switches on triple tempo for the rest of the module.
              if (param_q == 7'd0) begin
                tempo_d = 1'b1;
              end
              if (param_q > ptd_pkg::SpeedMax) begin
                kind_d  = ptd_pkg::KIND_NONE;
                param_d = 7'd0;
              end else begin
                kind_d  = ptd_pkg::KIND_SPEED;
                param_d = tempo_d ? ({param_q[5:0], 1'b0} + param_q) : param_q;
              end
            end
            default: kind_d = ptd_pkg::KIND_UNMAPPED;
          endcase
        end
        default: begin
          phase_d = ptd_pkg::PH_PARAM;
          if (row_inc >= {1'b0, RowsEnd}) begin
            row_d = RowsEnd;
            fin_d = 1'b1;
          end else begin
            row_d = row_inc[RowW-1:0];
          end
          has_result_o          = 1'b1;
          result_o.event_valid  = 1'b1;
          result_o.row          = row_in[5:0];
          result_o.note         = note;
          result_o.instrument   = {b[0], ins_hi_q};
          result_o.effect_kind  = kind_q;
          result_o.effect_param = param_q;
          result_o.effect_raw   = raw_q;
          result_o.track_end    = fin_d;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ptd_pkg::PH_PARAM;
      row_q    <= '0;
      tempo_q  <= 1'b0;
      fin_q    <= 1'b0;
      param_q  <= '0;
      ins_hi_q <= '0;
      kind_q   <= ptd_pkg::KIND_NONE;
      raw_q    <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      row_q    <= row_d;
      tempo_q  <= tempo_d;
      fin_q    <= fin_d;
      param_q  <= param_d;
      ins_hi_q <= ins_hi_d;
      kind_q   <= kind_d;
      raw_q    <= raw_d;
    end
  end

  assign status_o.finished = fin_q;
  assign status_o.row      = row_q;

endmodule

`default_nettype wire

FILE: rtl/core/ptd_output_stage.sv
// ----------------------------------------------------------------------------
// ptd_output_stage
// Result register: holds one decoded word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_output_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire ptd_pkg::out_item_t data_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  output ptd_pkg::out_item_t      out_data_o,
  input  wire logic               out_ready_i
);

  logic               valid_q, valid_d;
  ptd_pkg::out_item_t data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/packed_track_event_decoder.sv
// ----------------------------------------------------------------------------
// packed_track_event_decoder
// Decodes a packed tracker track, one byte per word, into note events.
//
// Channels: in_i takes one track byte per word together with the track and
// module start marks; out_o gives one word per decoded event, and one word
// with event_valid low and track_end high when a row skip runs past the end.
// Skip bytes that stay inside the track and the first two bytes of an event
// give no word; bytes after the track end are dropped until the next start.
// A byte taken on in_i is held in the input register and decoded from it
// combinationally; its word is loaded into the result register, from which it
// is on out_o until taken. Throughput: one byte per cycle while the receiver
// does not stall; the only loop is the update of phase and row.
// When the receiver stalls, the result register holds its word; one more
// byte waits in the input register, and in_i.ready then drops, unless that
// byte gives no word, in which case decoding goes on.
// Reset clears the phase, row, tempo mode and both valid flags; the block
// takes bytes in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_track_event_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ptd_in_if.sink     in_i,
  ptd_out_if.source  out_o
);

  logic                 s1_valid;
  ptd_pkg::in_item_t    s1_data;
  logic                 advance;
  logic                 has_result;
  logic                 out_free;
  ptd_pkg::out_item_t   result;
  ptd_pkg::dec_status_t status;

  // A byte leaves the input register unless it makes a word that cannot land.
  assign advance = s1_valid && (!has_result || out_free);

  ptd_input_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_data_i  (in_i.data),
    .in_ready_o (in_i.ready),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .data_o     (s1_data)
  );

  ptd_decode u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (s1_data),
    .fire_i       (advance),
    .has_result_o (has_result),
    .result_o     (result),
    .status_o     (status)
  );

  ptd_output_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .data_i      (result),
    .free_o      (out_free),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data),
    .out_ready_i (out_o.ready)
  );

  a_end_word_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.data.event_valid) |-> out_o.data.track_end)
    else $error("word without event does not mark the track end");

  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.row <= ptd_pkg::RowW'(ptd_pkg::RowsPerTrack))
    else $error("row counter beyond the end of the track");

  a_silent_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && status.finished && !s1_data.track_start && !s1_data.module_start)
      |-> !has_result)
    else $error("word produced after the track end");

  a_finished_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.finished |-> (status.row == ptd_pkg::RowW'(ptd_pkg::RowsPerTrack)))
    else $error("finished track with row short of the end");

endmodule

`default_nettype wire
